>>> rtl/dhcpopt_pkg.sv
// Shared types, option codes and the store-slot lookup for the DHCP options parser.
// No dependencies.
package dhcpopt_pkg;

  localparam int NumSlots  = 6;
  localparam int SlotW     = 3;
  localparam int WordW     = 32;
  localparam int ByteW     = 8;
  localparam int SeenW     = 7;

  localparam logic [ByteW-1:0] CODE_PAD    = 8'd0;
  localparam logic [ByteW-1:0] CODE_MASK   = 8'd1;
  localparam logic [ByteW-1:0] CODE_ROUTER = 8'd3;
  localparam logic [ByteW-1:0] CODE_DNS    = 8'd6;
  localparam logic [ByteW-1:0] CODE_CLIENT = 8'd50;
  localparam logic [ByteW-1:0] CODE_LEASE  = 8'd51;
  localparam logic [ByteW-1:0] CODE_TYPE   = 8'd53;
  localparam logic [ByteW-1:0] CODE_SERVER = 8'd54;
  localparam logic [ByteW-1:0] CODE_END    = 8'd255;

  localparam logic [ByteW-1:0] LAST_WORD_IDX = 8'd3;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] idx;
  } slot_t;

  typedef struct packed {
    logic [ByteW-1:0]           message_type;
    logic [NumSlots-1:0][WordW-1:0] vals;
    logic [SeenW-1:0]           seen_mask;
    logic                       ended_by_end_code;
  } result_t;

  function automatic slot_t slot_of(input logic [ByteW-1:0] code);
    slot_t s;
    s.hit = 1'b1;
    s.idx = '0;
    case (code)
      CODE_MASK:   s.idx = 3'd0;
      CODE_ROUTER: s.idx = 3'd1;
      CODE_DNS:    s.idx = 3'd2;
      CODE_CLIENT: s.idx = 3'd3;
      CODE_LEASE:  s.idx = 3'd4;
      CODE_SERVER: s.idx = 3'd5;
      default:     s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/dhcpopt_walker.sv
// Code/length/data record walker with the persistent option stores.
// Depends on dhcpopt_pkg.
module dhcpopt_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             opt_byte,
  input  logic                   area_last,
  output logic                   res_valid,
  output dhcpopt_pkg::result_t   res
);
  import dhcpopt_pkg::*;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] cur_code, cur_code_next;
  logic [ByteW-1:0] rec_len, rec_len_next;
  logic [ByteW-1:0] remaining, remaining_next;
  logic [WordW-1:0] word, word_next;
  logic [ByteW-1:0] type_store, type_store_next;
  logic [NumSlots-1:0][WordW-1:0] vals, vals_next;
  logic [SeenW-1:0] seen, seen_next;

  logic [SeenW-1:0] res_seen;
  logic             by_end;
  logic             restart;
  logic [ByteW-1:0] idx;
  logic [WordW-1:0] shifted;
  slot_t            slot;

  assign idx     = rec_len - remaining;
  assign shifted = {word[WordW-ByteW-1:0], opt_byte};
  assign slot    = slot_of(cur_code);

  always_comb begin
    phase_next      = phase;
    cur_code_next   = cur_code;
    rec_len_next    = rec_len;
    remaining_next  = remaining;
    word_next       = word;
    type_store_next = type_store;
    vals_next       = vals;
    seen_next       = seen;
    res_valid       = 1'b0;
    res_seen        = seen;
    by_end          = 1'b0;
    restart         = 1'b0;

    case (phase)
      PH_CODE: begin
        if (opt_byte == CODE_END) begin
          res_valid = 1'b1;
          by_end    = 1'b1;
          if (area_last) begin
            restart = 1'b1;
          end else begin
            seen_next  = '0;
            phase_next = PH_TRAIL;
          end
        end else if (opt_byte != CODE_PAD) begin
          cur_code_next = opt_byte;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        rec_len_next   = opt_byte;
        remaining_next = opt_byte;
        word_next      = '0;
        phase_next     = (opt_byte == '0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        if (idx <= LAST_WORD_IDX) word_next = shifted;
        if (idx == '0 && cur_code == CODE_TYPE) begin
          type_store_next = opt_byte;
          seen_next[0]    = 1'b1;
        end
        if (idx == LAST_WORD_IDX && slot.hit) begin
          vals_next[slot.idx]            = shifted;
          seen_next[slot.idx + 3'd1]     = 1'b1;
        end
        remaining_next = remaining - 8'd1;
        if (remaining == 8'd1) phase_next = PH_CODE;
      end
      PH_TRAIL: begin
        if (area_last) restart = 1'b1;
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // truncated area: result at the last byte unless already handled above
    if (area_last && !res_valid && phase != PH_TRAIL) begin
      res_valid = 1'b1;
      res_seen  = seen_next;
      restart   = 1'b1;
    end

    if (restart) begin
      phase_next     = PH_CODE;
      cur_code_next  = '0;
      rec_len_next   = '0;
      remaining_next = '0;
      word_next      = '0;
      seen_next      = '0;
    end
  end

  assign res.message_type      = type_store_next;
  assign res.vals              = vals_next;
  assign res.seen_mask         = res_seen;
  assign res.ended_by_end_code = by_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CODE;
      cur_code   <= '0;
      rec_len    <= '0;
      remaining  <= '0;
      word       <= '0;
      type_store <= '0;
      vals       <= '0;
      seen       <= '0;
    end else if (step) begin
      phase      <= phase_next;
      cur_code   <= cur_code_next;
      rec_len    <= rec_len_next;
      remaining  <= remaining_next;
      word       <= word_next;
      type_store <= type_store_next;
      vals       <= vals_next;
      seen       <= seen_next;
    end
  end

endmodule

>>> rtl/dhcp_option_tlv_parser.sv
// DHCP options-area parser: takes one options byte per request and returns one
// result per message, at the end code or at the byte marked last, whichever comes
// first. Codes 1, 3, 6, 50, 51 and 54 load a 32-bit store from the first four data
// bytes (big-endian) when the record has at least four; code 53 loads the type from
// its first data byte; pad is skipped. Stores persist across messages, seen_mask
// covers the current message only. One byte is taken per cycle unless input stalls,
// and each result is registered; a two-entry output stage (result plus skid)
// keeps input flowing while a result waits, and input stalls only when both hold.
// Depends on dhcpopt_pkg and dhcpopt_walker.
module dhcp_option_tlv_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opt_byte,
  input  logic        area_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  message_type,
  output logic [31:0] subnet_mask,
  output logic [31:0] router_addr,
  output logic [31:0] dns_addr,
  output logic [31:0] client_addr,
  output logic [31:0] lease_seconds,
  output logic [31:0] server_addr,
  output logic [6:0]  seen_mask,
  output logic        ended_by_end_code
);
  import dhcpopt_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_reg;
  result_t skid;
  logic    skid_valid;

  assign in_ready = !skid_valid;
  assign step     = in_valid && in_ready;

  dhcpopt_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .opt_byte  (opt_byte),
    .area_last (area_last),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_reg    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (step && res_valid) begin
      if (!out_valid || out_ready) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign message_type      = out_reg.message_type;
  assign subnet_mask       = out_reg.vals[0];
  assign router_addr       = out_reg.vals[1];
  assign dns_addr          = out_reg.vals[2];
  assign client_addr       = out_reg.vals[3];
  assign lease_seconds     = out_reg.vals[4];
  assign server_addr       = out_reg.vals[5];
  assign seen_mask         = out_reg.seen_mask;
  assign ended_by_end_code = out_reg.ended_by_end_code;

endmodule

>>> bench/dhcp_option_result_checker.sv
// Watches the byte and result channels of the DHCP options parser, predicts each
// message summary from the accepted option bytes and compares it field by field.
// Depends on dhcpopt_pkg for phase and option codes.
`timescale 1ns / 1ps

module dhcp_option_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  opt_byte,
  input  logic        area_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  message_type,
  input  logic [31:0] subnet_mask,
  input  logic [31:0] router_addr,
  input  logic [31:0] dns_addr,
  input  logic [31:0] client_addr,
  input  logic [31:0] lease_seconds,
  input  logic [31:0] server_addr,
  input  logic [6:0]  seen_mask,
  input  logic        ended_by_end_code,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          end_closed
);
  import dhcpopt_pkg::*;

  typedef struct packed {
    logic [7:0]       mtype;
    logic [5:0][31:0] addr;
    logic [6:0]       seen;
    logic             by_end;
  } opt_summary_t;

  opt_summary_t     expected_summaries[$];

  phase_t           parse_ph;
  logic [7:0]       rec_code;
  logic [7:0]       rec_len;
  logic [7:0]       data_left;
  logic [31:0]      word_acc;
  logic [7:0]       type_val;
  logic [5:0][31:0] addr_store;
  logic [6:0]       seen_flags;

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    end_closed      = 0;
  end

  function automatic int store_slot(input logic [7:0] c);
    case (c)
      CODE_MASK:   return 0;
      CODE_ROUTER: return 1;
      CODE_DNS:    return 2;
      CODE_CLIENT: return 3;
      CODE_LEASE:  return 4;
      CODE_SERVER: return 5;
      default:     return -1;
    endcase
  endfunction

  task automatic restart_message();
    parse_ph   = PH_CODE;
    rec_code   = '0;
    rec_len    = '0;
    data_left  = '0;
    word_acc   = '0;
    seen_flags = '0;
  endtask

  task automatic push_summary(input logic by_end);
    opt_summary_t s;
    s.mtype  = type_val;
    s.addr   = addr_store;
    s.seen   = seen_flags;
    s.by_end = by_end;
    expected_summaries.push_back(s);
  endtask

  task automatic parse_option_byte(input logic [7:0] b, input logic last);
    logic [7:0] idx;
    int         slot;
    case (parse_ph)
      PH_CODE: begin
        if (b == CODE_END) begin
          push_summary(1'b1);
          if (last) begin
            restart_message();
          end else begin
            seen_flags = '0;
            parse_ph   = PH_TRAIL;
          end
          return;
        end
        if (b != CODE_PAD) begin
          rec_code = b;
          parse_ph = PH_LEN;
        end
      end
      PH_LEN: begin
        rec_len   = b;
        data_left = b;
        word_acc  = '0;
        parse_ph  = (b == '0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        idx = rec_len - data_left;
        if (idx <= LAST_WORD_IDX) word_acc = {word_acc[23:0], b};
        if (idx == '0 && rec_code == CODE_TYPE) begin
          type_val      = b;
          seen_flags[0] = 1'b1;
        end
        if (idx == LAST_WORD_IDX) begin
          slot = store_slot(rec_code);
          if (slot >= 0) begin
            addr_store[3'(slot)]     = word_acc;
            seen_flags[3'(slot + 1)] = 1'b1;
          end
        end
        data_left = data_left - 8'd1;
        if (data_left == '0) parse_ph = PH_CODE;
      end
      default: begin
        if (last) restart_message();
        return;
      end
    endcase
    if (last) begin
      push_summary(1'b0);
      restart_message();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    opt_summary_t want;
    if (rst) begin
      restart_message();
      type_val   = '0;
      addr_store = '0;
      expected_summaries.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t: unexpected result, expected none, got type %0h seen %0h end %0b",
                   $time, message_type, seen_mask, ended_by_end_code);
          fail_count++;
        end else begin
          want = expected_summaries.pop_front();
          results_checked++;
          if (want.by_end) end_closed++;
          check_field("message_type", 32'(want.mtype), 32'(message_type));
          check_field("subnet_mask", want.addr[0], subnet_mask);
          check_field("router_addr", want.addr[1], router_addr);
          check_field("dns_addr", want.addr[2], dns_addr);
          check_field("client_addr", want.addr[3], client_addr);
          check_field("lease_seconds", want.addr[4], lease_seconds);
          check_field("server_addr", want.addr[5], server_addr);
          check_field("seen_mask", 32'(want.seen), 32'(seen_mask));
          check_field("ended_by_end_code", 32'(want.by_end), 32'(ended_by_end_code));
        end
      end
      if (in_valid && in_ready) parse_option_byte(opt_byte, area_last);
    end
    pending <= expected_summaries.size();
  end

endmodule

>>> bench/dhcp_option_tlv_parser_tb.sv
// Top of the DHCP options parser bench: clock, reset, option byte stimulus with
// random idling on both channels, watchdog and verdict.
// Depends on dhcpopt_pkg, dhcp_option_tlv_parser and dhcp_option_result_checker.
`timescale 1ns / 1ps

module dhcp_option_tlv_parser_tb;
  import dhcpopt_pkg::*;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  opt_byte;
  logic        area_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  message_type;
  logic [31:0] subnet_mask;
  logic [31:0] router_addr;
  logic [31:0] dns_addr;
  logic [31:0] client_addr;
  logic [31:0] lease_seconds;
  logic [31:0] server_addr;
  logic [6:0]  seen_mask;
  logic        ended_by_end_code;

  int          mismatches;
  int          pending;
  int          results_checked;
  int          end_closed;

  int          items;
  int          idle_cycles;
  bit          quiet;
  bit          hold_req;
  bit          hold_active;
  logic [7:0]  msg[$];

  dhcp_option_tlv_parser dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opt_byte          (opt_byte),
    .area_last         (area_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .message_type      (message_type),
    .subnet_mask       (subnet_mask),
    .router_addr       (router_addr),
    .dns_addr          (dns_addr),
    .client_addr       (client_addr),
    .lease_seconds     (lease_seconds),
    .server_addr       (server_addr),
    .seen_mask         (seen_mask),
    .ended_by_end_code (ended_by_end_code)
  );

  dhcp_option_result_checker u_results (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opt_byte          (opt_byte),
    .area_last         (area_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .message_type      (message_type),
    .subnet_mask       (subnet_mask),
    .router_addr       (router_addr),
    .dns_addr          (dns_addr),
    .client_addr       (client_addr),
    .lease_seconds     (lease_seconds),
    .server_addr       (server_addr),
    .seen_mask         (seen_mask),
    .ended_by_end_code (ended_by_end_code),
    .fail_count        (mismatches),
    .pending           (pending),
    .results_checked   (results_checked),
    .end_closed        (end_closed)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic logic [7:0] known_code();
    case ($urandom_range(0, 6))
      0:       return CODE_MASK;
      1:       return CODE_ROUTER;
      2:       return CODE_DNS;
      3:       return CODE_CLIENT;
      4:       return CODE_LEASE;
      5:       return CODE_TYPE;
      default: return CODE_SERVER;
    endcase
  endfunction

  // receiver: random ready runs and gaps, one long hold-off on request
  initial begin
    out_ready   = 1'b0;
    hold_active = 1'b0;
    @(posedge clk);
    forever begin
      int gap;
      int run;
      if (hold_req) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 10);
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no request or result moved for %0d cycles", $time, StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opt_byte  <= b;
    area_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) send_req(msg[i], i == msg.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly well-formed option areas, some cut short, some pure noise
  task automatic build_message();
    int nrec;
    int len;
    int r;
    int cut;
    logic [7:0] c;
    msg.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 24);
      repeat (len) msg.push_back(rand_byte());
      return;
    end
    nrec = $urandom_range(0, 6);
    repeat (nrec) begin
      while ($urandom_range(0, 4) == 0) msg.push_back(CODE_PAD);
      if ($urandom_range(0, 9) < 8) c = known_code();
      else c = 8'($urandom_range(1, 254));
      r = $urandom_range(0, 99);
      if (r < 60) len = (c == CODE_TYPE) ? 1 : 4;
      else if (r < 70) len = 0;
      else if (r < 82) len = $urandom_range(1, 3);
      else if (r < 93) len = $urandom_range(5, 10);
      else if (r < 99) len = $urandom_range(11, 40);
      else len = $urandom_range(200, 255);
      msg.push_back(c);
      msg.push_back(len[7:0]);
      repeat (len) begin
        if (c == CODE_TYPE && $urandom_range(0, 1)) msg.push_back(8'($urandom_range(1, 8)));
        else msg.push_back(rand_byte());
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      msg.push_back(CODE_END);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) msg.push_back(rand_byte());
    end else if (msg.size() > 1 && $urandom_range(0, 1)) begin
      cut = $urandom_range(1, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end
    if (msg.size() == 0) msg.push_back(CODE_END);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    opt_byte  = '0;
    area_last = 1'b0;
    items     = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // pad, type at its top value, router, end code, trailing byte
    msg = {CODE_PAD, CODE_TYPE, 8'd1, 8'hff, CODE_ROUTER, 8'd4, 8'hde, 8'had, 8'hbe,
           8'hef, CODE_END, 8'h5a};
    send_message();
    // zero length, long lease record, unknown code, server cut off in mid-data
    msg = {CODE_DNS, 8'd0, CODE_LEASE, 8'd5, 8'h01, 8'h02, 8'h03, 8'h04, 8'hff,
           8'd200, 8'd1, 8'h00, CODE_SERVER, 8'd4, 8'hc0};
    send_message();
    msg = {CODE_END};
    send_message();
    msg = {CODE_MASK};
    send_message();
    drain();

    quiet = 1'b1;
    while (items < 320) begin
      build_message();
      send_message();
    end
    quiet = 1'b0;
    drain();

    while (items < 620) begin
      build_message();
      send_message();
    end

    // receiver holds off while one-byte messages keep coming
    in_valid <= 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    quiet = 1'b1;
    repeat (40) begin
      msg = {rand_byte()};
      send_message();
    end
    quiet = 1'b0;
    drain();

    while (items < 900) begin
      build_message();
      send_message();
    end
    drain();

    while (items < 1150) begin
      build_message();
      send_message();
    end
    drain();
    repeat (16) @(posedge clk);

    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    $display("Covered %0d option bytes and %0d message results (%0d closed by end code,",
             items, results_checked, end_closed);
    $display("  %0d cut short), with idling on both sides and an output hold-off.",
             results_checked - end_closed);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
